FILE: rtl/core/lrutl_pkg.sv
// ----------------------------------------------------------------------------
// lrutl_pkg: shared types and constants of the two-level page store
// Status and operation codes, default sizes, controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package lrutl_pkg;
    localparam int FastSlotsDef = 8;
    localparam int SlowSlotsDef = 64;
    localparam int KeyBitsDef   = 16;
    localparam int InKeyW       = 16;
    localparam int ValW         = 32;

    localparam logic [1:0] KIND_STORE   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP  = 2'd2;

    localparam logic [2:0] ST_STORED_FAST = 3'd0;
    localparam logic [2:0] ST_STORED_SLOW = 3'd1;
    localparam logic [2:0] ST_RELEASED    = 3'd2;
    localparam logic [2:0] ST_REL_MISS    = 3'd3;
    localparam logic [2:0] ST_HIT         = 3'd4;
    localparam logic [2:0] ST_SWAP_HIT    = 3'd5;
    localparam logic [2:0] ST_MISS        = 3'd6;
    localparam logic [2:0] ST_FULL        = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture input item, do fast-tier work
        logic scan;       // step backing scan one entry
        logic swap;       // write swap results
        logic slow_store; // write store into current backing entry
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_slow;  // item needs the backing tier
        logic is_store;
        logic match;      // current backing entry is a candidate
        logic last;       // current backing entry is the last
    } sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/lrutl_if.sv
// ----------------------------------------------------------------------------
// lrutl_if: valid/ready channel
// Carries one item of width W from source to sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface lrutl_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lru_two_level_page_store.sv
// ----------------------------------------------------------------------------
// lru_two_level_page_store: keyed two-level store with recency swapping
// Usage: items enter on in_ch {kind, item_key, item_value, now_stamp}; one
// result {status, read_value} leaves on out_ch per item.
// Store with a free fast slot, release, unknown kinds and fast-tier hits:
// the result is valid right after the accepting edge.
// Items that need the backing tier (store with fast tier full, lookup
// missing the fast tier) walk the backing memory one entry per cycle
// through its single read port and stop at a hit or at a free entry.
// One item is in flight at a time; in_ch.ready drops from accept until
// the result is taken and returns the next cycle.
// A stalled receiver holds the result valid and stable.
// Reset clears all used bits and fast stamps at once; the backing memory
// needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_two_level_page_store #(
    parameter int FAST_SLOTS = lrutl_pkg::FastSlotsDef,
    parameter int SLOW_SLOTS = lrutl_pkg::SlowSlotsDef,
    parameter int KEY_BITS   = lrutl_pkg::KeyBitsDef
) (
    input wire logic clk,
    input wire logic rst_n,
    lrutl_if.sink    in_ch,
    lrutl_if.source  out_ch
);
    lrutl_pkg::cmd_t cmd;
    lrutl_pkg::sts_t sts;
    logic [2:0]  status;
    logic [31:0] read_value;

    lrutl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .sts(sts)
    );

    lrutl_dp #(.FAST_SLOTS(FAST_SLOTS), .SLOW_SLOTS(SLOW_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .kind(in_ch.data[81:80]), .item_key(in_ch.data[79:64]),
        .item_value(in_ch.data[63:32]), .now_stamp(in_ch.data[31:0]),
        .cmd(cmd), .sts(sts), .status(status), .read_value(read_value)
    );

    assign out_ch.data = {status, read_value};

    // no new item while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("ready with result pending");
    // a result waiting on a stalled receiver holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    // results other than hits carry zero value
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && status != lrutl_pkg::ST_HIT && status != lrutl_pkg::ST_SWAP_HIT
        |-> read_value == '0) else $error("stray read value");
endmodule
`default_nettype wire

FILE: rtl/core/lrutl_ctrl.sv
// ----------------------------------------------------------------------------
// lrutl_ctrl: sequencer of the page store
// Accepts an item, runs the backing scan if needed, presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lrutl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lrutl_pkg::cmd_t     cmd,
    input  wire lrutl_pkg::sts_t sts
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;
    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        cmd.latch = in_valid && in_ready;
        if (state_reg == S_SCAN)
        begin
            cmd.scan       = !sts.match && !sts.last;
            cmd.swap       = sts.match && !sts.is_store;
            cmd.slow_store = sts.match && sts.is_store;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= sts.need_slow ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN:
                begin
                    if (sts.match || sts.last)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/lrutl_dp.sv
// ----------------------------------------------------------------------------
// lrutl_dp: datapath of the page store
// Fast tier in flip-flops with parallel match; backing tier in a memory
// walked one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lrutl_dp #(
    parameter int FAST_SLOTS = lrutl_pkg::FastSlotsDef,
    parameter int SLOW_SLOTS = lrutl_pkg::SlowSlotsDef,
    parameter int KEY_BITS   = lrutl_pkg::KeyBitsDef
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            kind,
    input  wire logic [lrutl_pkg::InKeyW-1:0] item_key,
    input  wire logic [lrutl_pkg::ValW-1:0]   item_value,
    input  wire logic [lrutl_pkg::ValW-1:0]   now_stamp,
    input  wire lrutl_pkg::cmd_t       cmd,
    output lrutl_pkg::sts_t            sts,
    output logic [2:0]                 status,
    output logic [lrutl_pkg::ValW-1:0] read_value
);
    localparam int FW  = (FAST_SLOTS > 1) ? $clog2(FAST_SLOTS) : 1;
    localparam int SW  = (SLOW_SLOTS > 1) ? $clog2(SLOW_SLOTS) : 1;
    localparam int KW  = (KEY_BITS < lrutl_pkg::InKeyW) ? KEY_BITS : lrutl_pkg::InKeyW;
    localparam int VW  = lrutl_pkg::ValW;
    localparam int SLW = KW + 2 * VW;

    logic [KW-1:0] fast_key_reg   [FAST_SLOTS];
    logic [VW-1:0] fast_value_reg [FAST_SLOTS];
    logic [VW-1:0] fast_stamp_reg [FAST_SLOTS];
    logic [FAST_SLOTS-1:0] fast_used_reg;
    logic [SLOW_SLOTS-1:0] slow_used_reg;
    logic [SLW-1:0] slow_mem [SLOW_SLOTS];

    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg, now_reg;
    logic          store_reg;
    logic [SW-1:0] idx_reg;
    logic [FW-1:0] vic_reg;
    logic [2:0]    status_reg;
    logic [VW-1:0] rv_reg;
    logic [SLW-1:0] rd_reg;

    logic [KW-1:0] in_key;
    assign in_key = item_key[KW-1:0];

    // fast-tier match, free slot and least-stamp victim
    logic          hit, any_free;
    logic [FW-1:0] hit_idx, free_idx, lru_idx;
    always_comb
    begin
        hit = 1'b0; hit_idx = '0; any_free = 1'b0; free_idx = '0; lru_idx = '0;
        for (int i = FAST_SLOTS - 1; i >= 0; i--)
        begin
            if (fast_used_reg[i] && fast_key_reg[i] == in_key)
            begin
                hit = 1'b1; hit_idx = FW'(i);
            end
            if (!fast_used_reg[i])
            begin
                any_free = 1'b1; free_idx = FW'(i);
            end
        end
        for (int i = 1; i < FAST_SLOTS; i++)
        begin
            if (fast_stamp_reg[i] < fast_stamp_reg[lru_idx])
            begin
                lru_idx = FW'(i);
            end
        end
    end

    logic need_slow;
    assign need_slow = (kind == lrutl_pkg::KIND_STORE) ? !any_free
                     : (kind == lrutl_pkg::KIND_LOOKUP) ? !hit : 1'b0;

    // current backing entry (memory read data is registered, so a lookup
    // entry counts only when the registered read address equals the index)
    logic [SW-1:0] rd_idx_reg;
    logic          rd_ok;
    logic [KW-1:0] rd_key;
    assign rd_key = rd_reg[SLW-1 -: KW];
    assign rd_ok  = (rd_idx_reg == idx_reg);
    always_comb
    begin
        sts.need_slow = need_slow;
        sts.is_store  = store_reg;
        if (store_reg)
        begin
            sts.match = !slow_used_reg[idx_reg];
        end
        else
        begin
            sts.match = rd_ok && slow_used_reg[idx_reg] && rd_key == key_reg;
        end
        sts.last = (rd_ok || store_reg) && (idx_reg == SW'(SLOW_SLOTS - 1));
    end

    logic [SW-1:0] idx_next;
    assign idx_next = (rd_ok || store_reg) ? idx_reg + SW'(1) : idx_reg;

    // backing memory port
    always_ff @(posedge clk)
    begin
        rd_reg     <= slow_mem[cmd.latch ? '0 : idx_next];
        rd_idx_reg <= cmd.latch ? '0 : idx_next;
        if (cmd.swap)
        begin
            slow_mem[idx_reg] <= {fast_key_reg[vic_reg], fast_value_reg[vic_reg], now_reg};
        end
        else if (cmd.slow_store)
        begin
            slow_mem[idx_reg] <= {key_reg, val_reg, {VW{1'b0}}};
        end
    end

    // item registers and fast-tier payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg   <= in_key;
            val_reg   <= item_value;
            now_reg   <= now_stamp;
            store_reg <= (kind == lrutl_pkg::KIND_STORE);
            idx_reg   <= '0;
            vic_reg   <= any_free ? free_idx : lru_idx;
            rv_reg    <= (kind == lrutl_pkg::KIND_LOOKUP && hit) ? fast_value_reg[hit_idx] : '0;
            case (kind)
                lrutl_pkg::KIND_STORE:
                begin
                    status_reg <= any_free ? lrutl_pkg::ST_STORED_FAST : lrutl_pkg::ST_FULL;
                    if (any_free)
                    begin
                        fast_key_reg[free_idx]   <= in_key;
                        fast_value_reg[free_idx] <= item_value;
                    end
                end
                lrutl_pkg::KIND_RELEASE:
                    status_reg <= hit ? lrutl_pkg::ST_RELEASED : lrutl_pkg::ST_REL_MISS;
                lrutl_pkg::KIND_LOOKUP:
                    status_reg <= hit ? lrutl_pkg::ST_HIT : lrutl_pkg::ST_MISS;
                default: status_reg <= lrutl_pkg::ST_MISS;
            endcase
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_next;
        end
        else if (cmd.swap)
        begin
            fast_key_reg[vic_reg]   <= rd_key;
            fast_value_reg[vic_reg] <= rd_reg[VW +: VW];
            rv_reg     <= rd_reg[VW +: VW];
            status_reg <= lrutl_pkg::ST_SWAP_HIT;
        end
        else if (cmd.slow_store)
        begin
            status_reg <= lrutl_pkg::ST_STORED_SLOW;
        end
    end

    // used bits and fast stamps (reset to zero)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_used_reg <= '0;
            slow_used_reg <= '0;
            for (int i = 0; i < FAST_SLOTS; i++)
            begin
                fast_stamp_reg[i] <= '0;
            end
        end
        else if (cmd.latch)
        begin
            if (kind == lrutl_pkg::KIND_STORE && any_free)
            begin
                fast_used_reg[free_idx]  <= 1'b1;
                fast_stamp_reg[free_idx] <= now_stamp;
            end
            else if (kind == lrutl_pkg::KIND_RELEASE && hit)
            begin
                fast_used_reg[hit_idx] <= 1'b0;
            end
            else if (kind == lrutl_pkg::KIND_LOOKUP && hit)
            begin
                fast_stamp_reg[hit_idx] <= now_stamp;
            end
        end
        else if (cmd.swap)
        begin
            slow_used_reg[idx_reg]  <= fast_used_reg[vic_reg];
            fast_used_reg[vic_reg]  <= 1'b1;
            fast_stamp_reg[vic_reg] <= rd_reg[VW-1:0];
        end
        else if (cmd.slow_store)
        begin
            slow_used_reg[idx_reg] <= 1'b1;
        end
    end

    assign status     = status_reg;
    assign read_value = rv_reg;
endmodule
`default_nettype wire

FILE: tb/sv/lru_two_level_page_store_tb.sv
// ----------------------------------------------------------------------------
// lru_two_level_page_store_tb: self-checking bench for the two-level store
// Random store/release/lookup traffic mostly on a small key set, checked item
// by item against an internal model of both tiers, under idle and stall phases.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_two_level_page_store_tb;
    localparam int NF = 8;
    localparam int NS = 64;
    localparam int IN_W = 2 + lrutl_pkg::InKeyW + 2 * lrutl_pkg::ValW;
    localparam int OUT_W = 3 + lrutl_pkg::ValW;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [15:0]                item_key;
        logic [lrutl_pkg::ValW-1:0] item_value;
        logic [lrutl_pkg::ValW-1:0] now_stamp;
    } req_t;

    typedef struct packed {
        logic [2:0]                 status;
        logic [lrutl_pkg::ValW-1:0] read_value;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lrutl_if #(.W(IN_W))  in_ch ();
    lrutl_if #(.W(OUT_W)) out_ch ();

    lru_two_level_page_store i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 clk = ~clk;

    // shadow copy of both tiers
    logic [15:0] fk [NF];
    logic [31:0] fv [NF];
    logic [31:0] fs [NF];
    logic        fu [NF];
    logic [15:0] sk [NS];
    logic [31:0] sv [NS];
    logic [31:0] ss [NS];
    logic        su [NS];

    req_t pending_items[$];
    rsp_t expected_results[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    logic stimulus_done = 1'b0;

    // compute the result of one item and update the shadow tiers
    function automatic rsp_t predict_store_result(req_t r);
        rsp_t res;
        int   f;
        int   s;
        int   v;
        logic [15:0] ek;
        logic [31:0] ev;
        logic        eu;
        res = '{status: lrutl_pkg::ST_MISS, read_value: '0};
        f = -1;
        s = -1;
        v = -1;
        if (r.kind == lrutl_pkg::KIND_STORE)
        begin
            res.status = lrutl_pkg::ST_FULL;
            for (int i = 0; i < NF && f < 0; i++)
                if (!fu[i]) f = i;
            if (f >= 0)
            begin
                fk[f] = r.item_key; fv[f] = r.item_value;
                fs[f] = r.now_stamp; fu[f] = 1'b1;
                res.status = lrutl_pkg::ST_STORED_FAST;
            end
            else
            begin
                for (int i = 0; i < NS && s < 0; i++)
                    if (!su[i]) s = i;
                if (s >= 0)
                begin
                    sk[s] = r.item_key; sv[s] = r.item_value;
                    ss[s] = '0; su[s] = 1'b1;
                    res.status = lrutl_pkg::ST_STORED_SLOW;
                end
            end
        end
        else if (r.kind == lrutl_pkg::KIND_RELEASE || r.kind == lrutl_pkg::KIND_LOOKUP)
        begin
            for (int i = 0; i < NF && f < 0; i++)
                if (fu[i] && fk[i] == r.item_key) f = i;
            if (r.kind == lrutl_pkg::KIND_RELEASE)
            begin
                res.status = (f >= 0) ? lrutl_pkg::ST_RELEASED : lrutl_pkg::ST_REL_MISS;
                if (f >= 0) fu[f] = 1'b0;
            end
            else if (f >= 0)
            begin
                fs[f] = r.now_stamp;
                res = '{status: lrutl_pkg::ST_HIT, read_value: fv[f]};
            end
            else
            begin
                for (int i = 0; i < NS && s < 0; i++)
                    if (su[i] && sk[i] == r.item_key) s = i;
                if (s >= 0)
                begin
                    // victim: lowest free slot, else least stamp
                    for (int i = 0; i < NF && v < 0; i++)
                        if (!fu[i]) v = i;
                    if (v < 0)
                    begin
                        v = 0;
                        for (int i = 1; i < NF; i++)
                            if (fs[i] < fs[v]) v = i;
                    end
                    ek = fk[v]; ev = fv[v]; eu = fu[v];
                    fk[v] = sk[s]; fv[v] = sv[s]; fs[v] = ss[s]; fu[v] = 1'b1;
                    sk[s] = ek; sv[s] = ev; ss[s] = r.now_stamp; su[s] = eu;
                    res = '{status: lrutl_pkg::ST_SWAP_HIT, read_value: fv[v]};
                end
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_store_result(in_ch.data));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_items.pop_front();
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t got;
        rsp_t exp_r;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d value=%h",
                                 got.status, got.read_value);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status=%0d value=%h, got status=%0d value=%h",
                                     exp_r.status, exp_r.read_value,
                                     got.status, got.read_value);
                    end
                end
            end
        end
    end

    function automatic req_t make_item(logic [1:0] k, logic [15:0] key,
                                       logic [31:0] val, logic [31:0] stamp);
        req_t r;
        r = '{kind: k, item_key: key, item_value: val, now_stamp: stamp};
        return r;
    endfunction

    // key drawn mostly from a small pool so that hits and swaps are common
    function automatic logic [15:0] pick_key();
        if ($urandom_range(9) < 8)
            return 16'(16'hFFF0 ^ $urandom_range(23));
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 2) return 2'd3;
        if (p < 40) return lrutl_pkg::KIND_STORE;
        if (p < 60) return lrutl_pkg::KIND_RELEASE;
        return lrutl_pkg::KIND_LOOKUP;
    endfunction

    // stimulus and phases
    initial
    begin
        int phase_idle [4] = '{0, 68, 0, 24};
        int phase_stall [4] = '{0, 0, 68, 24};
        for (int i = 0; i < NF; i++)
        begin
            fu[i] = 1'b0;
            fs[i] = '0;
        end
        for (int i = 0; i < NS; i++) su[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: misses on empty store, extremes, fill the fast tier and spill into the backing tier, swaps
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'hFFFF, '0, '0));
        pending_items.push_back(make_item(lrutl_pkg::KIND_RELEASE, 16'h0000, '0, '1));
        pending_items.push_back(make_item(2'd3, 16'hFFFF, '1, '1));
        pending_items.push_back(make_item(lrutl_pkg::KIND_STORE, 16'h0000, '1, '1));
        pending_items.push_back(make_item(lrutl_pkg::KIND_STORE, 16'hFFFF, '0, '0));
        pending_items.push_back(make_item(lrutl_pkg::KIND_STORE, 16'hFFFF,
                                          32'h5A5A_A5A5, 32'd7));
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'hFFFF, '0, 32'd9));
        pending_items.push_back(make_item(lrutl_pkg::KIND_RELEASE, 16'hFFFF, '0, '0));
        for (int i = 0; i < 10; i++)
            pending_items.push_back(make_item(lrutl_pkg::KIND_STORE, 16'(i + 16'h100),
                                              32'(i * 32'h1111_1111), 32'(i + 3)));
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'h0108, '0, 32'd100));
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'h0109, '0, 32'd101));
        pending_items.push_back(make_item(lrutl_pkg::KIND_RELEASE, 16'h0103, '0, '0));
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'h0100, '0, '1));
        pending_items.push_back(make_item(lrutl_pkg::KIND_LOOKUP, 16'h0108, '0, 32'd5));

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < 390; n++)
                pending_items.push_back(make_item(pick_kind(), pick_key(),
                                                  $urandom, $urandom));
            // fill the backing tier toward full once
            if (p == 1)
                for (int n = 0; n < 70; n++)
                    pending_items.push_back(make_item(lrutl_pkg::KIND_STORE, pick_key(),
                                                      $urandom, $urandom));
            while (pending_items.size() > 0) @(posedge clk);
        end
        stimulus_done = 1'b1;
    end

    // end of run and watchdog
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG)
            begin
                $display("FAIL lru_two_level_page_store");
                $finish;
            end
            if (stimulus_done && !in_ch.valid && expected_results.size() == 0)
            begin
                repeat (3 * NS) @(posedge clk);
                if (mismatches == 0 && expected_results.size() == 0)
                    $display("PASS lru_two_level_page_store");
                else
                    $display("FAIL lru_two_level_page_store");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire
